// ===== design/cau_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// Complex arithmetic unit package
// Shared types, opcodes and defaults for the complex arithmetic unit.
// ---------------------------------------------------------------------------
package cau_pkg;

   localparam int DataWidthDefault = 16;
   localparam int FracBitsDefault  = 8;

   typedef enum logic [2:0] {
      OP_ADD  = 3'd0,
      OP_SUB  = 3'd1,
      OP_MUL  = 3'd2,
      OP_DIV  = 3'd3,
      OP_EQU  = 3'd4,
      OP_CONJ = 3'd5
   } op_type;

   localparam logic [1:0] ST_OK  = 2'd0;
   localparam logic [1:0] ST_SAT = 2'd1;
   localparam logic [1:0] ST_DVZ = 2'd2;

   typedef struct packed {
      logic [2:0]                       op_code;
      logic signed [DataWidthDefault-1:0] a_re;
      logic signed [DataWidthDefault-1:0] a_im;
      logic signed [DataWidthDefault-1:0] b_re;
      logic signed [DataWidthDefault-1:0] b_im;
   } req_type;

   typedef struct packed {
      logic signed [DataWidthDefault-1:0] res_re;
      logic signed [DataWidthDefault-1:0] res_im;
      logic                             is_equal;
      logic [1:0]                       status;
   } rsp_type;

endpackage
`default_nettype wire

// ===== design/complex_arithmetic_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Path from request acceptance to result: queue, product stage, combine stage,
// the long-division stages (one quotient bit each) and the saturation stage.
// Throughput: one request per cycle unless stalled; division is fully pipelined.
// Reset clears the queue and all pipeline valid bits; data registers are not reset.
// ---------------------------------------------------------------------------
// Complex arithmetic unit
// Front queue feeding the arithmetic pipeline.
// ---------------------------------------------------------------------------
module complex_arithmetic_unit #(
   parameter int FRAC_BITS  = cau_pkg::FracBitsDefault
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_stall,
   input  wire cau_pkg::req_type req_data,
   output logic                  rsp_valid,
   input  wire logic             rsp_stall,
   output cau_pkg::rsp_type      rsp_data
);
   import cau_pkg::*;

   logic    q_valid, q_stall;
   req_type q_data;

   cau_queue u_queue (
      .clock(clock), .reset(reset),
      .in_valid(req_valid), .in_stall(req_stall), .in_data(req_data),
      .out_valid(q_valid), .out_stall(q_stall), .out_data(q_data)
   );

   cau_back #(.FRAC_BITS(FRAC_BITS)) u_back (
      .clock(clock), .reset(reset),
      .in_valid(q_valid), .in_stall(q_stall), .in_data(q_data),
      .out_valid(rsp_valid), .out_stall(rsp_stall), .out_data(rsp_data)
   );
endmodule
`default_nettype wire

// ===== design/cau_queue.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// Complex arithmetic unit queue
// Two-entry queue between the front and the back part.
// ---------------------------------------------------------------------------
module cau_queue (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            in_valid,
   output logic                 in_stall,
   input  wire cau_pkg::req_type in_data,
   output logic                 out_valid,
   input  wire logic            out_stall,
   output cau_pkg::req_type     out_data
);
   import cau_pkg::*;

   req_type    mem_ff [2];
   logic       wr_ff, wr_in, rd_ff, rd_in;
   logic [1:0] cnt_ff, cnt_in;
   logic       push, pop;

   assign in_stall  = (cnt_ff == 2'd2);
   assign out_valid = (cnt_ff != 2'd0);
   assign out_data  = mem_ff[rd_ff];
   assign push      = in_valid && !in_stall;
   assign pop       = out_valid && !out_stall;

   always_comb begin
      wr_in  = push ? ~wr_ff : wr_ff;
      rd_in  = pop ? ~rd_ff : rd_ff;
      cnt_in = cnt_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= 1'b0;
         rd_ff  <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
      if (push) begin
         mem_ff[wr_ff] <= in_data;
      end
   end
endmodule
`default_nettype wire

// ===== design/cau_back.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// Complex arithmetic unit back part
// Pipeline: products, combine, long division, saturation and output.
// ---------------------------------------------------------------------------
module cau_back #(
   parameter int FRAC_BITS  = cau_pkg::FracBitsDefault
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             in_valid,
   output logic                  in_stall,
   input  wire cau_pkg::req_type in_data,
   output logic                  out_valid,
   input  wire logic             out_stall,
   output cau_pkg::rsp_type      out_data
);
   import cau_pkg::*;

   localparam int W  = DataWidthDefault;
   localparam int PW = 2 * W + 2;
   localparam int NW = PW + FRAC_BITS;
   localparam int QS = NW;
   localparam int NST = QS + 3;

   typedef struct packed {
      logic [2:0]          op;
      logic signed [PW-1:0] x;
      logic signed [PW-1:0] y;
      logic [PW-1:0]       den;
      logic                eq;
   } s1_type;

   typedef struct packed {
      logic [2:0]      op;
      logic            xn;
      logic            yn;
      logic [NW-1:0]   xr;
      logic [NW-1:0]   yr;
      logic [NW-1:0]   xq;
      logic [NW-1:0]   yq;
      logic [PW-1:0]   den;
      logic            eq;
      logic signed [NW:0] xv;
      logic signed [NW:0] yv;
   } dv_type;

   logic           adv;
   logic [NST-1:0] vld_ff;
   s1_type         s1_ff, s1_in;
   dv_type         st_ff [QS+1];
   dv_type         st_in [QS+1];
   rsp_type        out_ff, out_in;

   assign adv       = !(vld_ff[NST-1] && out_stall);
   assign in_stall  = !adv;
   assign out_valid = vld_ff[NST-1];
   assign out_data  = out_ff;

   always_comb begin
      logic signed [W:0]    ar, ai, br, bi;
      logic signed [PW-1:0] p_rr, p_ii, p_ri, p_ir;
      ar = {in_data.a_re[W-1], in_data.a_re};
      ai = {in_data.a_im[W-1], in_data.a_im};
      br = {in_data.b_re[W-1], in_data.b_re};
      bi = {in_data.b_im[W-1], in_data.b_im};
      p_rr = PW'(ar * br);
      p_ii = PW'(ai * bi);
      p_ri = PW'(ar * bi);
      p_ir = PW'(ai * br);
      s1_in.op  = in_data.op_code;
      s1_in.eq  = (in_data.a_re == in_data.b_re) && (in_data.a_im == in_data.b_im);
      s1_in.den = PW'(br * br) + PW'(bi * bi);
      case (in_data.op_code)
         OP_ADD: begin
            s1_in.x = PW'(ar + br);
            s1_in.y = PW'(ai + bi);
         end
         OP_SUB: begin
            s1_in.x = PW'(ar - br);
            s1_in.y = PW'(ai - bi);
         end
         OP_MUL: begin
            s1_in.x = p_rr - p_ii;
            s1_in.y = p_ri + p_ir;
         end
         OP_DIV: begin
            s1_in.x = p_rr + p_ii;
            s1_in.y = p_ir - p_ri;
         end
         OP_CONJ: begin
            s1_in.x = PW'(ar);
            s1_in.y = PW'(-ai);
         end
         default: begin
            s1_in.x = '0;
            s1_in.y = '0;
         end
      endcase
   end

   always_comb begin
      logic [NW-1:0] xm, ym;
      st_in[0].op  = s1_ff.op;
      st_in[0].den = s1_ff.den;
      st_in[0].eq  = s1_ff.eq;
      st_in[0].xv  = (s1_ff.op == OP_MUL) ? (NW+1)'(s1_ff.x >>> FRAC_BITS)
                                          : (NW+1)'(s1_ff.x);
      st_in[0].yv  = (s1_ff.op == OP_MUL) ? (NW+1)'(s1_ff.y >>> FRAC_BITS)
                                          : (NW+1)'(s1_ff.y);
      st_in[0].xn  = s1_ff.x[PW-1];
      st_in[0].yn  = s1_ff.y[PW-1];
      xm = NW'(s1_ff.x[PW-1] ? -s1_ff.x : s1_ff.x) << FRAC_BITS;
      ym = NW'(s1_ff.y[PW-1] ? -s1_ff.y : s1_ff.y) << FRAC_BITS;
      st_in[0].xq = xm;
      st_in[0].yq = ym;
      st_in[0].xr = '0;
      st_in[0].yr = '0;
      for (int k = 1; k <= QS; k++) begin
         logic [NW:0] tx, ty;
         st_in[k] = st_ff[k-1];
         tx = {st_ff[k-1].xr, st_ff[k-1].xq[NW-1]};
         ty = {st_ff[k-1].yr, st_ff[k-1].yq[NW-1]};
         st_in[k].xq = {st_ff[k-1].xq[NW-2:0], 1'b0};
         st_in[k].yq = {st_ff[k-1].yq[NW-2:0], 1'b0};
         if (tx >= (NW+1)'(st_ff[k-1].den)) begin
            tx = tx - (NW+1)'(st_ff[k-1].den);
            st_in[k].xq[0] = 1'b1;
         end
         if (ty >= (NW+1)'(st_ff[k-1].den)) begin
            ty = ty - (NW+1)'(st_ff[k-1].den);
            st_in[k].yq[0] = 1'b1;
         end
         st_in[k].xr = NW'(tx);
         st_in[k].yr = NW'(ty);
      end
   end

   function automatic logic [W:0] sat(input logic signed [NW+1:0] v);
      logic [W:0] r;
      if (v > (NW+2)'((2 ** (W - 1)) - 1)) r = {2'b10, {(W-1){1'b1}}};
      else if (v < -(NW+2)'(2 ** (W - 1))) r = {2'b11, {(W-1){1'b0}}};
      else r = {1'b0, v[W-1:0]};
      return r;
   endfunction

   always_comb begin
      dv_type         f;
      logic signed [NW+1:0] xs, ys;
      logic [W:0]     rx, ry;
      f = st_ff[QS];
      out_in = '0;
      if (f.op == OP_DIV) begin
         xs = f.xn ? -(NW+2)'(f.xq) : (NW+2)'(f.xq);
         ys = f.yn ? -(NW+2)'(f.yq) : (NW+2)'(f.yq);
      end else begin
         xs = (NW+2)'(f.xv);
         ys = (NW+2)'(f.yv);
      end
      rx = sat(xs);
      ry = sat(ys);
      case (f.op)
         OP_ADD, OP_SUB, OP_MUL, OP_CONJ: begin
            out_in.res_re = rx[W-1:0];
            out_in.res_im = ry[W-1:0];
            out_in.status = (rx[W] || ry[W]) ? ST_SAT : ST_OK;
         end
         OP_DIV: begin
            if (f.den == '0) begin
               out_in.status = ST_DVZ;
            end else begin
               out_in.res_re = rx[W-1:0];
               out_in.res_im = ry[W-1:0];
               out_in.status = (rx[W] || ry[W]) ? ST_SAT : ST_OK;
            end
         end
         OP_EQU: out_in.is_equal = f.eq;
         default: out_in = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= {vld_ff[NST-2:0], in_valid};
      end
      if (adv) begin
         s1_ff <= s1_in;
         for (int k = 0; k <= QS; k++) st_ff[k] <= st_in[k];
         out_ff <= out_in;
      end
   end
endmodule
`default_nettype wire

// ===== design/cau_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// Complex arithmetic unit checker
// Port-level properties of the complex arithmetic unit.
// ---------------------------------------------------------------------------
module cau_checker (
   input wire logic             clock,
   input wire logic             reset,
   input wire logic             rsp_valid,
   input wire logic             rsp_stall,
   input wire cau_pkg::rsp_type rsp_data
);
   import cau_pkg::*;

   a_status: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.status <= ST_DVZ) else $error("bad status");
   a_eq: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.is_equal |-> rsp_data.res_re == 0 && rsp_data.res_im == 0)
      else $error("compare result not zero");
   a_dvz: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.status == ST_DVZ |-> rsp_data.res_re == 0)
      else $error("zero divisor result not zero");
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data)) else $error("rsp dropped");
endmodule

bind complex_arithmetic_unit cau_checker u_cau_checker (
   .clock(clock), .reset(reset), .rsp_valid(rsp_valid),
   .rsp_stall(rsp_stall), .rsp_data(rsp_data)
);
`default_nettype wire
